// ===== hdl/rasst_pkg.sv =====
// Shared types, constants and node update function for the range add/assign sum tree.
package rasst_pkg;

   localparam int MAX_ELEMENTS_DEF = 1024;
   localparam int POS_W            = 11;
   localparam int VAL_W            = 32;
   localparam int SUM_W            = 64;
   localparam int LVL_W            = 5;
   localparam logic [POS_W-1:0] ACT_LEN_RESET = 11'd1024;

   typedef enum logic [1:0] {
      REQ_ADD = 2'd0,
      REQ_SET = 2'd1,
      REQ_SUM = 2'd2,
      REQ_NOP = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_ADD  = 2'd1,
      KIND_SET  = 2'd2
   } lazy_kind_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [SUM_W-1:0] lazy;
      lazy_kind_type    kind;
   } node_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PUSH_CHK,
      ST_PUSH_PAR,
      ST_PUSH_LEFT,
      ST_PUSH_RIGHT,
      ST_APPLY_LO,
      ST_APPLY_LO_WR,
      ST_APPLY_HI,
      ST_APPLY_HI_WR,
      ST_APPLY_SHIFT,
      ST_UPD_CHK,
      ST_UPD_LEFT,
      ST_UPD_RIGHT
   } state_type;

   // Apply an add or an assign to a node spanning 2**k elements.
   function automatic node_type node_apply(node_type n, logic [SUM_W-1:0] v, logic set,
                                           logic [LVL_W-1:0] k);
      node_type         r;
      logic [SUM_W-1:0] part;
      part = v << k;
      r    = n;
      if (set) begin
         r.sum  = part;
         r.lazy = v;
         r.kind = KIND_SET;
      end else begin
         r.sum  = n.sum + part;
         r.lazy = n.lazy + v;
         if (n.kind != KIND_SET) begin
            r.kind = KIND_ADD;
         end
      end
      return r;
   endfunction

endpackage

// ===== hdl/range_add_assign_sum_tree.sv =====
// Top level: lazy sum tree with range add, range assign and range sum requests.
//
// Usage: after reset the block clears all 2*2**ceil(log2(MAX_ELEMENTS)) node
// locations (2048 for the default), one node per cycle, with busy high;
// configuration writes are taken throughout. A request is taken when start is
// high and busy is low. A no-op request, or an add or assign whose clipped
// range is empty, finishes in the cycle it is taken; an empty query returns 0
// on the next cycle. Any other request walks the tree through the single node
// memory: a downward pass that pushes pending values along the two boundary
// paths (a node with something pending is cleared and its value applied to
// both children), a level-by-level pass over the covered nodes and, for add
// and assign, an upward pass that refreshes the boundary sums. The shortest
// request is a one-element query with nothing pending, the longest a wide add
// with pending values along both boundaries; the memory port is the
// bottleneck. A query result appears on rsp_range_sum for exactly one cycle
// with rsp_valid high and cannot be held off.
module range_add_assign_sum_tree #(
   parameter int MAX_ELEMENTS = rasst_pkg::MAX_ELEMENTS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [1:0]                     req_type,
   input  logic [rasst_pkg::POS_W-1:0]    req_range_left,
   input  logic [rasst_pkg::POS_W-1:0]    req_range_right,
   input  logic signed [rasst_pkg::VAL_W-1:0] req_operand_value,
   output logic                           rsp_valid,
   output logic signed [rasst_pkg::SUM_W-1:0] rsp_range_sum,
   input  logic                           csr_write_en,
   input  logic [rasst_pkg::POS_W-1:0]    csr_active_length
);

   // tree geometry: leaves at N..2N-1, root at 1
   localparam int LOG = $clog2(MAX_ELEMENTS);
   localparam int N   = 1 << LOG;
   localparam int NW  = LOG + 1;   // node address
   localparam int IW  = LOG + 2;   // boundary index, may reach 2N
   localparam int PW  = rasst_pkg::POS_W;
   localparam int SW  = rasst_pkg::SUM_W;
   localparam int LW  = rasst_pkg::LVL_W;

   rasst_pkg::state_type state_ff, state_in;
   logic [LW-1:0]        lvl_ff, lvl_in;
   logic                 side_ff, side_in;
   logic [NW-1:0]        node_ff, node_in;
   logic [IW-1:0]        lo_ff, lo_in, hi_ff, hi_in;
   logic [IW-1:0]        lorg_ff, lorg_in, rorg_ff, rorg_in;
   logic [LW-1:0]        k_ff, k_in;
   logic                 op_set_ff, op_set_in, op_sum_ff, op_sum_in;
   logic [SW-1:0]        val_ff, val_in;
   rasst_pkg::node_type  par_ff, par_in;
   logic [SW-1:0]        s0_ff, s0_in;
   logic [SW-1:0]        acc_ff, acc_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]        rsp_sum_ff, rsp_sum_in;
   logic [PW-1:0]        act_ff, act_in;
   logic [NW-1:0]        clr_ff, clr_in;

   // memory port
   logic                 mem_we, mem_re;
   logic [NW-1:0]        mem_waddr, mem_raddr;
   rasst_pkg::node_type  mem_wdata, mem_rdata;

   // request decode
   logic [PW-1:0]        clip_l, clip_r;
   logic                 clip_empty;
   logic [31:0]          lo_wide, hi_wide;

   // boundary path helpers
   logic [IW-1:0]        pth_src, pth_base;
   logic [NW-1:0]        pth_node;
   logic                 pth_cut;
   logic [NW-1:0]        child0, child1;
   logic [IW-1:0]        hi_dec;

   // pass advance
   rasst_pkg::state_type push_adv_state, upd_adv_state;
   logic [LW-1:0]        push_adv_lvl, upd_adv_lvl;

   rasst_node_ram #(.NW(NW)) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign busy          = (state_ff != rasst_pkg::ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_range_sum = rsp_sum_ff;

   always_comb begin
      clip_l     = (req_range_left == '0) ? PW'(1) : req_range_left;
      clip_r     = (req_range_right > act_ff) ? act_ff : req_range_right;
      clip_empty = clip_l > clip_r;
      lo_wide    = 32'(N) + 32'(clip_l) - 32'd1;
      hi_wide    = 32'(N) + 32'(clip_r);
   end

   always_comb begin
      pth_src  = side_ff ? rorg_ff : lorg_ff;
      pth_base = side_ff ? (rorg_ff - IW'(1)) : lorg_ff;
      pth_node = NW'(pth_base >> lvl_ff);
      pth_cut  = ((pth_src >> lvl_ff) << lvl_ff) != pth_src;
      child0   = {node_ff[NW-2:0], 1'b0};
      child1   = {node_ff[NW-2:0], 1'b1};
      hi_dec   = hi_ff - IW'(1);
   end

   // push pass runs from the top level down, at each level the left path then the right path
   always_comb begin
      push_adv_state = rasst_pkg::ST_PUSH_CHK;
      push_adv_lvl   = lvl_ff;
      if (side_ff) begin
         if (lvl_ff == LW'(1)) begin
            push_adv_state = rasst_pkg::ST_APPLY_LO;
         end else begin
            push_adv_lvl = lvl_ff - LW'(1);
         end
      end
      upd_adv_state = rasst_pkg::ST_UPD_CHK;
      upd_adv_lvl   = lvl_ff;
      if (side_ff) begin
         if (lvl_ff == LW'(LOG)) begin
            upd_adv_state = rasst_pkg::ST_IDLE;
         end else begin
            upd_adv_lvl = lvl_ff + LW'(1);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      lvl_in       = lvl_ff;
      side_in      = side_ff;
      node_in      = node_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      lorg_in      = lorg_ff;
      rorg_in      = rorg_ff;
      k_in         = k_ff;
      op_set_in    = op_set_ff;
      op_sum_in    = op_sum_ff;
      val_in       = val_ff;
      par_in       = par_ff;
      s0_in        = s0_ff;
      acc_in       = acc_ff;
      rsp_valid_in = 1'b0;
      rsp_sum_in   = rsp_sum_ff;
      act_in       = act_ff;
      clr_in       = clr_ff;
      mem_we       = 1'b0;
      mem_waddr    = node_ff;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = node_ff;

      if (csr_write_en) begin
         if (csr_active_length == '0) begin
            act_in = PW'(1);
         end else if (32'(csr_active_length) > 32'(MAX_ELEMENTS)) begin
            act_in = PW'(MAX_ELEMENTS);
         end else begin
            act_in = csr_active_length;
         end
      end

      case (state_ff)
         rasst_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + NW'(1);
            if (&clr_ff) begin
               state_in = rasst_pkg::ST_IDLE;
            end
         end
         rasst_pkg::ST_IDLE: begin
            if (start && req_type != rasst_pkg::REQ_NOP) begin
               op_set_in = (req_type == rasst_pkg::REQ_SET);
               op_sum_in = (req_type == rasst_pkg::REQ_SUM);
               val_in    = SW'(req_operand_value);
               acc_in    = '0;
               lorg_in   = lo_wide[IW-1:0];
               rorg_in   = hi_wide[IW-1:0];
               lvl_in    = LW'(LOG);
               side_in   = 1'b0;
               if (clip_empty) begin
                  if (req_type == rasst_pkg::REQ_SUM) begin
                     rsp_valid_in = 1'b1;
                     rsp_sum_in   = '0;
                  end
               end else begin
                  state_in = rasst_pkg::ST_PUSH_CHK;
               end
            end
         end
         rasst_pkg::ST_PUSH_CHK: begin
            lo_in = lorg_ff;
            hi_in = rorg_ff;
            k_in  = '0;
            if (pth_cut) begin
               mem_re    = 1'b1;
               mem_raddr = pth_node;
               node_in   = pth_node;
               state_in  = rasst_pkg::ST_PUSH_PAR;
            end else begin
               side_in  = ~side_ff;
               lvl_in   = push_adv_lvl;
               state_in = push_adv_state;
            end
         end
         rasst_pkg::ST_PUSH_PAR: begin
            par_in = mem_rdata;
            if (mem_rdata.kind == rasst_pkg::KIND_NONE) begin
               side_in  = ~side_ff;
               lvl_in   = push_adv_lvl;
               state_in = push_adv_state;
            end else begin
               mem_we         = 1'b1;
               mem_waddr      = node_ff;
               mem_wdata      = mem_rdata;
               mem_wdata.lazy = '0;
               mem_wdata.kind = rasst_pkg::KIND_NONE;
               mem_re         = 1'b1;
               mem_raddr      = child0;
               state_in       = rasst_pkg::ST_PUSH_LEFT;
            end
         end
         rasst_pkg::ST_PUSH_LEFT: begin
            mem_we    = 1'b1;
            mem_waddr = child0;
            mem_wdata = rasst_pkg::node_apply(mem_rdata, par_ff.lazy,
                           par_ff.kind == rasst_pkg::KIND_SET, lvl_ff - LW'(1));
            mem_re    = 1'b1;
            mem_raddr = child1;
            state_in  = rasst_pkg::ST_PUSH_RIGHT;
         end
         rasst_pkg::ST_PUSH_RIGHT: begin
            mem_we    = 1'b1;
            mem_waddr = child1;
            mem_wdata = rasst_pkg::node_apply(mem_rdata, par_ff.lazy,
                           par_ff.kind == rasst_pkg::KIND_SET, lvl_ff - LW'(1));
            side_in   = ~side_ff;
            lvl_in    = push_adv_lvl;
            state_in  = push_adv_state;
         end
         rasst_pkg::ST_APPLY_LO: begin
            if (lo_ff >= hi_ff) begin
               if (op_sum_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_sum_in   = acc_ff;
                  state_in     = rasst_pkg::ST_IDLE;
               end else begin
                  lvl_in   = LW'(1);
                  side_in  = 1'b0;
                  state_in = rasst_pkg::ST_UPD_CHK;
               end
            end else if (lo_ff[0]) begin
               mem_re    = 1'b1;
               mem_raddr = lo_ff[NW-1:0];
               state_in  = rasst_pkg::ST_APPLY_LO_WR;
            end else begin
               state_in = rasst_pkg::ST_APPLY_HI;
            end
         end
         rasst_pkg::ST_APPLY_LO_WR: begin
            if (op_sum_ff) begin
               acc_in = acc_ff + mem_rdata.sum;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = lo_ff[NW-1:0];
               mem_wdata = rasst_pkg::node_apply(mem_rdata, val_ff, op_set_ff, k_ff);
            end
            lo_in    = lo_ff + IW'(1);
            state_in = rasst_pkg::ST_APPLY_HI;
         end
         rasst_pkg::ST_APPLY_HI: begin
            if (hi_ff[0]) begin
               mem_re    = 1'b1;
               mem_raddr = hi_dec[NW-1:0];
               hi_in     = hi_dec;
               state_in  = rasst_pkg::ST_APPLY_HI_WR;
            end else begin
               state_in = rasst_pkg::ST_APPLY_SHIFT;
            end
         end
         rasst_pkg::ST_APPLY_HI_WR: begin
            if (op_sum_ff) begin
               acc_in = acc_ff + mem_rdata.sum;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = hi_ff[NW-1:0];
               mem_wdata = rasst_pkg::node_apply(mem_rdata, val_ff, op_set_ff, k_ff);
            end
            state_in = rasst_pkg::ST_APPLY_SHIFT;
         end
         rasst_pkg::ST_APPLY_SHIFT: begin
            lo_in    = lo_ff >> 1;
            hi_in    = hi_ff >> 1;
            k_in     = k_ff + LW'(1);
            state_in = rasst_pkg::ST_APPLY_LO;
         end
         rasst_pkg::ST_UPD_CHK: begin
            if (pth_cut) begin
               node_in   = pth_node;
               mem_re    = 1'b1;
               mem_raddr = {pth_node[NW-2:0], 1'b0};
               state_in  = rasst_pkg::ST_UPD_LEFT;
            end else begin
               side_in  = ~side_ff;
               lvl_in   = upd_adv_lvl;
               state_in = upd_adv_state;
            end
         end
         rasst_pkg::ST_UPD_LEFT: begin
            s0_in     = mem_rdata.sum;
            mem_re    = 1'b1;
            mem_raddr = child1;
            state_in  = rasst_pkg::ST_UPD_RIGHT;
         end
         rasst_pkg::ST_UPD_RIGHT: begin
            mem_we        = 1'b1;
            mem_waddr     = node_ff;
            mem_wdata.sum = s0_ff + mem_rdata.sum;
            side_in       = ~side_ff;
            lvl_in        = upd_adv_lvl;
            state_in      = upd_adv_state;
         end
         default: begin
            state_in = rasst_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rasst_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         act_ff       <= (MAX_ELEMENTS < 1024) ? PW'(MAX_ELEMENTS) : rasst_pkg::ACT_LEN_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         act_ff       <= act_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff     <= lvl_in;
      side_ff    <= side_in;
      node_ff    <= node_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      lorg_ff    <= lorg_in;
      rorg_ff    <= rorg_in;
      k_ff       <= k_in;
      op_set_ff  <= op_set_in;
      op_sum_ff  <= op_sum_in;
      val_ff     <= val_in;
      par_ff     <= par_in;
      s0_ff      <= s0_in;
      acc_ff     <= acc_in;
      rsp_sum_ff <= rsp_sum_in;
   end

   // a pushed parent keeps its sum but loses its pending value
   a_push_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rasst_pkg::ST_PUSH_PAR && mem_we) |->
         (mem_wdata.kind == rasst_pkg::KIND_NONE && mem_wdata.lazy == '0))
      else $error("pushed parent still pending");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rasst_pkg::ST_IDLE) |-> !mem_we)
      else $error("node write while idle");

   a_apply_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rasst_pkg::ST_APPLY_SHIFT) |-> (lo_ff <= hi_ff))
      else $error("apply bounds crossed");

   a_push_level: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rasst_pkg::ST_PUSH_CHK) |-> (lvl_ff >= LW'(1) && lvl_ff <= LW'(LOG)))
      else $error("push level out of range");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff) == rasst_pkg::ST_IDLE ||
                     $past(state_ff) == rasst_pkg::ST_APPLY_LO))
      else $error("result from unexpected state");

endmodule

// ===== hdl/rasst_node_ram.sv =====
// Node store: one write port, one read port, registered read data.
module rasst_node_ram #(
   parameter int NW = 11
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [NW-1:0]       wr_addr,
   input  rasst_pkg::node_type wr_data,
   input  logic                rd_en,
   input  logic [NW-1:0]       rd_addr,
   output rasst_pkg::node_type rd_data
);

   rasst_pkg::node_type mem [2**NW];
   rasst_pkg::node_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
